### sv/dgsp_pkg.sv
package dgsp_pkg;

  localparam int MAX_VERTICES = 512;
  localparam int COST_BITS = 15;
  localparam int VTX_BITS = $clog2(MAX_VERTICES);
  localparam int CNT_BITS = VTX_BITS + 1;
  localparam int EDGE_ADDR_BITS = 2 * VTX_BITS;
  localparam int CFG_BITS = 10;
  localparam logic [COST_BITS-1:0] COST_INF = {COST_BITS{1'b1}};

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  typedef struct packed {
    logic [1:0]           command;
    logic [VTX_BITS-1:0]  row_vertex;
    logic [VTX_BITS-1:0]  col_vertex;
    logic [COST_BITS-1:0] edge_cost;
    logic [7:0]           edge_label;
  } in_item_t;

  typedef struct packed {
    logic [COST_BITS-1:0] distance;
    logic [VTX_BITS-1:0]  predecessor;
    logic                 reached;
  } out_item_t;

  typedef struct packed {
    logic [COST_BITS-1:0] path_cost;
    logic [VTX_BITS-1:0]  prev;
    logic                 settled;
  } vtx_t;

endpackage

### sv/dense_graph_shortest_path.sv
// Shortest-path engine over a dense directed graph held in an on-chip matrix.
// Input transactions use valid/ready and carry a command: write one edge,
// search from row_vertex to col_vertex, or read back one vertex's result.
// Each input transaction yields exactly one output transaction, held in an
// output register until the receiver takes it.
// An edge write is answered in the cycle after it is accepted.
// A read passes the vertex memory read register, then the output register.
// A search first loads n vertex entries from the source row, then per settled
// vertex scans all n entries for the minimum and, unless it is the target,
// relaxes that vertex's row, with n the vertex count capped at 512.
// The edge and vertex memories allow one access per cycle.
// After reset the edge memory is swept to "no edge", one entry per cycle;
// no input transaction is accepted during the sweep, but the vertex_count
// register may be written.
// While a result waits for out_ready, no new input transaction is accepted
// unless that result is taken in the same cycle.
module dense_graph_shortest_path
  import dgsp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CFG_BITS-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_INIT = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_RELAX = 3'd4;
  localparam logic [2:0] S_READ = 3'd5;

  localparam logic [EDGE_ADDR_BITS:0] CLR_LAST = {1'b0, {EDGE_ADDR_BITS{1'b1}}};
  localparam logic [CNT_BITS-1:0] N_MAX = CNT_BITS'(MAX_VERTICES);

  logic [2:0]                state;
  logic [CFG_BITS-1:0]       vertex_count;
  logic [EDGE_ADDR_BITS:0]   clr_cnt;
  logic [CNT_BITS-1:0]       cnt;
  logic                      pv;
  logic [VTX_BITS-1:0]       pidx;
  logic [VTX_BITS-1:0]       src;
  logic [VTX_BITS-1:0]       tgt;
  logic [VTX_BITS-1:0]       v;
  logic [COST_BITS-1:0]      minw;
  logic [VTX_BITS-1:0]       minv;
  logic [VTX_BITS-1:0]       minp;
  logic                      found;

  logic [CNT_BITS-1:0]       n;
  logic                      in_fire;
  logic                      out_fire;
  logic                      issue;
  logic                      last;

  logic                      ewe;
  logic [EDGE_ADDR_BITS-1:0] ewaddr;
  logic [COST_BITS-1:0]      ewdata;
  logic [EDGE_ADDR_BITS-1:0] eraddr;
  logic [COST_BITS-1:0]      erdata;

  logic                      vwe;
  logic [VTX_BITS-1:0]       vwaddr;
  vtx_t                      vwdata;
  logic [VTX_BITS-1:0]       vraddr;
  logic [$bits(vtx_t)-1:0]   vrdata_raw;
  vtx_t                      vr;

  logic                      take;
  logic [COST_BITS-1:0]      nminw;
  logic [VTX_BITS-1:0]       nminv;
  logic [VTX_BITS-1:0]       nminp;
  logic                      nfound;
  logic [COST_BITS:0]        sum;
  logic [COST_BITS-1:0]      sat;

  assign n = (vertex_count > CFG_BITS'(MAX_VERTICES)) ? N_MAX : CNT_BITS'(vertex_count);
  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign in_fire = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;
  assign issue = ((state == S_INIT) || (state == S_SCAN) || (state == S_RELAX)) && (cnt < n);
  assign last = pv && ({1'b0, pidx} == (n - CNT_BITS'(1)));
  assign vr = vtx_t'(vrdata_raw);

  assign take = pv && !vr.settled && (vr.path_cost < minw);
  assign nminw = take ? vr.path_cost : minw;
  assign nminv = take ? pidx : minv;
  assign nminp = take ? vr.prev : minp;
  assign nfound = found || take;

  assign sum = {1'b0, minw} + {1'b0, erdata};
  assign sat = (sum >= {1'b0, COST_INF}) ? COST_INF : sum[COST_BITS-1:0];

  assign eraddr = (state == S_INIT) ? {src, cnt[VTX_BITS-1:0]} : {v, cnt[VTX_BITS-1:0]};
  assign vraddr = (state == S_IDLE) ? in_data.row_vertex : cnt[VTX_BITS-1:0];

  always_comb begin
    ewe = 1'b0;
    ewaddr = clr_cnt[EDGE_ADDR_BITS-1:0];
    ewdata = COST_INF;
    if (state == S_CLEAR) begin
      ewe = 1'b1;
    end else if (in_fire && (in_data.command == CMD_WRITE)) begin
      ewe = 1'b1;
      ewaddr = {in_data.row_vertex, in_data.col_vertex};
      ewdata = (in_data.edge_label != 8'd0) ? in_data.edge_cost : COST_INF;
    end
  end

  always_comb begin
    vwe = 1'b0;
    vwaddr = pidx;
    vwdata = '{path_cost: sat, prev: v, settled: 1'b0};
    if ((state == S_INIT) && pv) begin
      vwe = 1'b1;
      if (pidx == src) begin
        vwdata = '{path_cost: '0, prev: src, settled: 1'b1};
      end else begin
        vwdata = '{path_cost: erdata, prev: src, settled: 1'b0};
      end
    end else if ((state == S_SCAN) && last && nfound && (nminv == tgt)) begin
      vwe = 1'b1;
      vwaddr = nminv;
      vwdata = '{path_cost: nminw, prev: nminp, settled: 1'b1};
    end else if ((state == S_RELAX) && pv) begin
      if (pidx == v) begin
        vwe = 1'b1;
        vwdata = '{path_cost: minw, prev: minp, settled: 1'b1};
      end else if (!vr.settled && (sat < vr.path_cost)) begin
        vwe = 1'b1;
      end
    end
  end

  dgsp_ram #(
    .WIDTH(COST_BITS),
    .DEPTH(MAX_VERTICES * MAX_VERTICES)
  ) u_edge_ram (
    .clk  (clk),
    .we   (ewe),
    .waddr(ewaddr),
    .wdata(ewdata),
    .raddr(eraddr),
    .rdata(erdata)
  );

  dgsp_ram #(
    .WIDTH($bits(vtx_t)),
    .DEPTH(MAX_VERTICES)
  ) u_vertex_ram (
    .clk  (clk),
    .we   (vwe),
    .waddr(vwaddr),
    .wdata(vwdata),
    .raddr(vraddr),
    .rdata(vrdata_raw)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= CFG_BITS'(1);
    end else if (cfg_write) begin
      vertex_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    pv <= issue;
    pidx <= cnt[VTX_BITS-1:0];
    if (issue) begin
      cnt <= cnt + CNT_BITS'(1);
    end
    if (state == S_SCAN) begin
      minw <= nminw;
      minv <= nminv;
      minp <= nminp;
      found <= nfound;
    end
    if (in_fire) begin
      src <= in_data.row_vertex;
      tgt <= in_data.col_vertex;
      cnt <= '0;
    end
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      pv <= 1'b0;
    end else begin
      if (out_fire) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_data.command)
              CMD_WRITE: begin
                out_valid <= 1'b1;
                out_data <= '{distance: '0, predecessor: '0, reached: 1'b0};
              end
              CMD_SEARCH: begin
                if (({1'b0, in_data.row_vertex} >= n) || ({1'b0, in_data.col_vertex} >= n)) begin
                  out_valid <= 1'b1;
                  out_data <= '{distance: COST_INF, predecessor: '0, reached: 1'b0};
                end else begin
                  state <= S_INIT;
                end
              end
              CMD_READ: begin
                state <= S_READ;
              end
              default: begin
                out_valid <= 1'b1;
                out_data <= '{distance: COST_INF, predecessor: '0, reached: 1'b0};
              end
            endcase
          end
        end
        S_READ: begin
          out_valid <= 1'b1;
          out_data <= '{distance: vr.path_cost, predecessor: vr.prev, reached: vr.settled};
          state <= S_IDLE;
        end
        S_INIT: begin
          if (last) begin
            cnt <= '0;
            if (src == tgt) begin
              out_valid <= 1'b1;
              out_data <= '{distance: '0, predecessor: src, reached: 1'b1};
              state <= S_IDLE;
            end else begin
              minw <= COST_INF;
              found <= 1'b0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (last) begin
            cnt <= '0;
            if (!nfound) begin
              out_valid <= 1'b1;
              out_data <= '{distance: COST_INF, predecessor: '0, reached: 1'b0};
              state <= S_IDLE;
            end else if (nminv == tgt) begin
              out_valid <= 1'b1;
              out_data <= '{distance: nminw, predecessor: nminp, reached: 1'b1};
              state <= S_IDLE;
            end else begin
              v <= nminv;
              state <= S_RELAX;
            end
          end
        end
        S_RELAX: begin
          if (last) begin
            cnt <= '0;
            minw <= COST_INF;
            found <= 1'b0;
            state <= S_SCAN;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_ready |-> (state == S_IDLE))
    else $error("Input accepted outside the idle state.");

  assert property (@(posedge clk) disable iff (rst) (state == S_CLEAR) |-> !out_valid)
    else $error("Result present during the edge memory sweep.");

  assert property (@(posedge clk) disable iff (rst)
    ((state == S_RELAX) && pv && (pidx == v)) |-> (vwe && vwdata.settled))
    else $error("Chosen vertex not marked settled during relaxation.");

  assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) && last && nfound) |-> (nminw != COST_INF))
    else $error("Scan selected a vertex with infinite distance.");

endmodule

### sv/dgsp_ram.sv
module dgsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sim/dense_graph_shortest_path_tb.sv
`timescale 1ns / 1ps

module dense_graph_shortest_path_tb;
  import dgsp_pkg::*;

  localparam int NV = MAX_VERTICES;
  localparam int IDLE_LIMIT = 2500000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic                clk;
  logic                rst;
  logic                cfg_write;
  logic [CFG_BITS-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;

  dense_graph_shortest_path dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  logic [COST_BITS-1:0] weight_mem [NV*NV];
  logic [7:0]           label_mem  [NV*NV];
  int                   best_dist  [NV];
  int                   prev_vtx   [NV];
  bit                   settled    [NV];
  int                   vertex_total;
  int                   written_extent;

  out_item_t pending_results[$];
  int        failures;
  int        hold_req;
  bit        no_gaps;
  int        idle_cycles;
  int        n_writes, n_searches, n_reached, n_reads, n_other;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic int short_or_long_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  function automatic out_item_t search_distance(int src, int tgt);
    out_item_t res;
    int        n;
    int        minw;
    int        v;
    int        sum;
    bit        found;
    res = '0;
    res.distance = COST_INF;
    n = (vertex_total < NV) ? vertex_total : NV;
    if (src >= n || tgt >= n) return res;
    for (int i = 0; i < n; i++) begin
      best_dist[i] = int'(weight_mem[src*NV+i]);
      prev_vtx[i] = src;
      settled[i] = 1'b0;
    end
    if (n > written_extent) written_extent = n;
    best_dist[src] = 0;
    settled[src] = 1'b1;
    if (src == tgt) begin
      res.distance = '0;
      res.predecessor = VTX_BITS'(src);
      res.reached = 1'b1;
      return res;
    end
    for (int i = 0; i + 1 < n; i++) begin
      minw = int'(COST_INF);
      v = 0;
      found = 1'b0;
      for (int j = 0; j < n; j++) begin
        if (!settled[j] && best_dist[j] < minw) begin
          v = j;
          minw = best_dist[j];
          found = 1'b1;
        end
      end
      if (!found) break;
      settled[v] = 1'b1;
      if (v == tgt) begin
        res.distance = COST_BITS'(minw);
        res.predecessor = VTX_BITS'(prev_vtx[v]);
        res.reached = 1'b1;
        return res;
      end
      for (int j = 0; j < n; j++) begin
        if (!settled[j] && label_mem[v*NV+j] != 0) begin
          sum = minw + int'(weight_mem[v*NV+j]);
          if (sum > int'(COST_INF)) sum = int'(COST_INF);
          if (sum < best_dist[j]) begin
            best_dist[j] = sum;
            prev_vtx[j] = v;
          end
        end
      end
    end
    return res;
  endfunction

  function automatic out_item_t graph_answer(in_item_t it);
    out_item_t res;
    res = '0;
    case (it.command)
      CMD_WRITE: begin
        label_mem[it.row_vertex*NV+it.col_vertex] = it.edge_label;
        weight_mem[it.row_vertex*NV+it.col_vertex] =
          (it.edge_label != 0) ? it.edge_cost : COST_INF;
        n_writes++;
      end
      CMD_SEARCH: begin
        res = search_distance(it.row_vertex, it.col_vertex);
        n_searches++;
        if (res.reached) n_reached++;
      end
      CMD_READ: begin
        res.distance = COST_BITS'(best_dist[it.row_vertex]);
        res.predecessor = VTX_BITS'(prev_vtx[it.row_vertex]);
        res.reached = settled[it.row_vertex];
        n_reads++;
      end
      default: begin
        res.distance = COST_INF;
        n_other++;
      end
    endcase
    return res;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = no_gaps ? 0 : short_or_long_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(graph_answer(it));
  endtask

  task automatic send_fields(logic [1:0] cmd, int row, int col, int cost, int lbl);
    in_item_t it;
    it.command = cmd;
    it.row_vertex = VTX_BITS'(row);
    it.col_vertex = VTX_BITS'(col);
    it.edge_cost = COST_BITS'(cost);
    it.edge_label = 8'(lbl);
    send_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_vertex_count(int value);
    drain();
    cfg_write <= 1'b1;
    cfg_data <= CFG_BITS'(value);
    @(posedge clk);
    cfg_write <= 1'b0;
    vertex_total = value;
  endtask

  task automatic send_random(int n, int n_search_max);
    int r;
    int lim;
    r = $urandom_range(0, 99);
    lim = (n < 1) ? 1 : ((n > NV) ? NV : n);
    if (r < 50 || (r < 70 && n_search_max == 0)) begin
      if ($urandom_range(0, 9) == 0)
        send_fields(CMD_WRITE, $urandom_range(0, NV-1), $urandom_range(0, NV-1),
                    $urandom_range(0, COST_INF), $urandom_range(0, 255));
      else
        send_fields(CMD_WRITE, $urandom_range(0, lim-1), $urandom_range(0, lim-1),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(COST_INF-20, COST_INF)
                                                : $urandom_range(0, 60),
                    ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 255));
    end else if (r < 75) begin
      if ($urandom_range(0, 9) == 0)
        send_fields(CMD_SEARCH, $urandom_range(0, NV-1), $urandom_range(0, NV-1),
                    $urandom, $urandom);
      else
        send_fields(CMD_SEARCH, $urandom_range(0, lim-1), $urandom_range(0, lim-1),
                    $urandom, $urandom);
    end else if (r < 96 && written_extent > 0) begin
      send_fields(CMD_READ, $urandom_range(0, written_extent-1), $urandom, $urandom,
                  $urandom);
    end else begin
      send_fields(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic test_directed();
    send_fields(CMD_SEARCH, 0, 0, 0, 0);
    send_fields(CMD_READ, 0, 0, 0, 0);
    send_fields(CMD_UNUSED, NV-1, NV-1, COST_INF, 255);
    send_fields(CMD_WRITE, NV-1, NV-1, COST_INF, 255);
    send_fields(CMD_WRITE, 0, 1, 0, 0);
    send_fields(CMD_SEARCH, 1, 0, 0, 0);
    set_vertex_count(8);
    send_fields(CMD_WRITE, 0, 1, 5, 1);
    send_fields(CMD_WRITE, 1, 2, COST_INF, 7);
    send_fields(CMD_WRITE, 0, 2, COST_INF-1, 2);
    send_fields(CMD_WRITE, 2, 3, 10, 3);
    send_fields(CMD_WRITE, 1, 4, 0, 255);
    send_fields(CMD_SEARCH, 0, 1, 0, 0);
    send_fields(CMD_SEARCH, 0, 4, 0, 0);
    send_fields(CMD_SEARCH, 0, 2, 0, 0);
    send_fields(CMD_READ, 1, 0, 0, 0);
    send_fields(CMD_SEARCH, 0, 3, 0, 0);
    send_fields(CMD_READ, 3, 0, 0, 0);
    send_fields(CMD_READ, 7, 0, 0, 0);
    send_fields(CMD_SEARCH, 0, 9, 0, 0);
    send_fields(CMD_SEARCH, 8, 0, 0, 0);
    send_fields(CMD_SEARCH, 5, 5, 0, 0);
    send_fields(CMD_SEARCH, 6, 2, 0, 0);
  endtask

  task automatic test_random_phase(int n, int items, int searches);
    int s;
    set_vertex_count(n);
    s = searches;
    for (int i = 0; i < items; i++) begin
      send_random(n, s);
      if (pending_results.size() > 0 && s > 0 && n_searches > 0) s = s;
    end
  endtask

  task automatic test_large_graph(int value, int items, int searches);
    int left;
    set_vertex_count(value);
    left = searches;
    for (int i = 0; i < items; i++) begin
      if (left > 0 && $urandom_range(0, 9) == 0) begin
        send_fields(CMD_SEARCH, $urandom_range(0, NV-1), $urandom_range(0, NV-1),
                    $urandom, $urandom);
        left--;
      end else begin
        send_random(value, 0);
      end
    end
    send_fields(CMD_SEARCH, NV-1, 0, 0, 0);
    send_fields(CMD_READ, NV-1, 0, 0, 0);
  endtask

  task automatic test_output_backpressure();
    set_vertex_count(12);
    hold_req = 400;
    no_gaps = 1'b1;
    for (int i = 0; i < 30; i++) send_random(12, 1);
    no_gaps = 1'b0;
    drain();
    for (int i = 0; i < 40; i++) send_random(12, 1);
  endtask

  always @(posedge clk) begin
    int stall_left;
    out_item_t want;
    if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result %p", out_data);
        failures++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.distance !== want.distance) begin
          $error("distance: expected %0d, actual %0d", want.distance, out_data.distance);
          failures++;
        end
        if (out_data.predecessor !== want.predecessor) begin
          $error("predecessor: expected %0d, actual %0d", want.predecessor,
                 out_data.predecessor);
          failures++;
        end
        if (out_data.reached !== want.reached) begin
          $error("reached: expected %0d, actual %0d", want.reached, out_data.reached);
          failures++;
        end
      end
    end
    if (hold_req > 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 4) == 0) stall_left = short_or_long_gap();
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    failures = 0;
    hold_req = 0;
    no_gaps = 1'b0;
    idle_cycles = 0;
    vertex_total = 1;
    written_extent = 0;
    for (int k = 0; k < NV*NV; k++) begin
      weight_mem[k] = COST_INF;
      label_mem[k] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_phase(2, 100, 1);
    test_random_phase(16, 450, 1);
    test_output_backpressure();
    test_random_phase(40, 350, 1);
    test_random_phase(1, 50, 1);
    test_random_phase(0, 30, 1);
    test_large_graph(NV, 80, 4);
    test_large_graph(1023, 30, 2);
    test_random_phase(10, 120, 1);
    drain();
    repeat (50) @(posedge clk);
    $display("Covered %0d edge writes, %0d searches (%0d reached), %0d reads, %0d unused",
             n_writes, n_searches, n_reached, n_reads, n_other);
    $display("Vertex counts from 0 to 1023 were used, with output stalls and input gaps.");
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
sv/dgsp_pkg.sv
sv/dgsp_ram.sv
sv/dense_graph_shortest_path.sv
sim/dense_graph_shortest_path_tb.sv
